>>> hw/rtl/asf_pkg.sv
// Package for the attractor spring force block: widths, config codes,
// reset values and the transaction structs. No dependencies.
package asf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int DIFF_W        = 33;
    localparam int SQ_W          = 66;
    localparam int GAIN_W        = 16;
    localparam int REST_W        = 31;
    localparam int CFG_W         = 31;
    localparam int AXES          = 3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;
    localparam logic [REST_W-1:0] REST_RESET = 31'd16384;

    typedef enum logic {
        CFG_SPRING_GAIN = 1'b0,
        CFG_REST_LENGTH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] part_x;
        logic signed [DATA_W-1:0] part_y;
        logic signed [DATA_W-1:0] part_z;
        logic signed [DATA_W-1:0] attr_x;
        logic signed [DATA_W-1:0] attr_y;
        logic signed [DATA_W-1:0] attr_z;
        logic                     last_attractor;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic signed [DATA_W-1:0] accel_z;
    } out_item_t;

    // difference vector as magnitude and sign per axis
    typedef struct packed {
        logic [AXES-1:0][DIFF_W-1:0] ad;
        logic [AXES-1:0]             dneg;
        logic                        last;
    } diff_item_t;

endpackage

>>> hw/rtl/asf_if.sv
// Valid/ready channel interfaces for input items and results.
// Depends on asf_pkg.
interface asf_item_if;
    import asf_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface asf_result_if;
    import asf_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/asf_front.sv
// Front end: takes input transactions and forms the difference vector.
// Depends on asf_pkg and asf_if.
module asf_front (
    input  logic                clk,
    input  logic                rst_n,
    asf_item_if.sink            item,
    output asf_pkg::diff_item_t q_data,
    output logic                q_valid,
    input  logic                q_ready
);
    import asf_pkg::*;

    logic                          valid_reg;
    diff_item_t                    data_reg;
    diff_item_t                    data_next;
    logic signed [AXES-1:0][DIFF_W-1:0] d;

    assign item.ready = !valid_reg || q_ready;
    assign q_valid    = valid_reg;
    assign q_data     = data_reg;

    always_comb
    begin
        d[0] = {item.payload.part_x[DATA_W-1], item.payload.part_x}
             - {item.payload.attr_x[DATA_W-1], item.payload.attr_x};
        d[1] = {item.payload.part_y[DATA_W-1], item.payload.part_y}
             - {item.payload.attr_y[DATA_W-1], item.payload.attr_y};
        d[2] = {item.payload.part_z[DATA_W-1], item.payload.part_z}
             - {item.payload.attr_z[DATA_W-1], item.payload.attr_z};
        for (int i = 0; i < AXES; i++)
        begin
            data_next.dneg[i] = d[i][DIFF_W-1];
            data_next.ad[i]   = d[i][DIFF_W-1] ? -d[i] : d[i];
        end
        data_next.last = item.payload.last_attractor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (item.ready)
            valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            data_reg <= data_next;
    end

endmodule

>>> hw/rtl/asf_queue.sv
// Two-entry queue between front and back end.
// Depends on asf_pkg.
module asf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  asf_pkg::diff_item_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output asf_pkg::diff_item_t rd_data
);
    import asf_pkg::*;

    diff_item_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> hw/rtl/asf_back.sv
// Back end: length by iterative square root, unit vector by three
// iterative dividers, spring scaling, saturating sums and result register.
// Depends on asf_pkg and asf_if.
module asf_back #(
    parameter int FRAC_BITS = asf_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  asf_pkg::diff_item_t         q_data,
    input  logic [asf_pkg::GAIN_W-1:0]  spring_gain,
    input  logic [asf_pkg::REST_W-1:0]  rest_length,
    asf_result_if.source                result
);
    import asf_pkg::*;

    localparam int ROOT_STEPS = DIFF_W;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int REM_W      = DIFF_W + 2;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQ   = 9'b000000010,
        S_SUM  = 9'b000000100,
        S_ROOT = 9'b000001000,
        S_PREP = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_MUL1 = 9'b001000000,
        S_MUL2 = 9'b010000000,
        S_ACC  = 9'b100000000
    } state_t;

    state_t                   state_reg;
    diff_item_t               item_reg;
    logic [AXES-1:0][SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]          rad_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DIFF_W-1:0]        root_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [AXES-1:0][DIFF_W:0]   drem_reg;
    logic [AXES-1:0][Q_W-1:0]    quo_reg;
    logic [DIFF_W-1:0]        ae_reg;
    logic                     eneg_reg;
    logic                     zero_reg;
    logic [AXES-1:0][DIFF_W-1:0] m_reg;
    logic [AXES-1:0][DIFF_W-1:0] c_reg;
    logic [AXES-1:0][DATA_W-1:0] sum_reg;
    logic [AXES-1:0][DATA_W-1:0] sum_next;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic [REM_W+1:0]         rem_sh;
    logic [REM_W+1:0]         trial;
    logic                     root_ge;
    logic signed [DIFF_W:0]   e;
    logic [AXES-1:0]          div_ge;
    logic [AXES-1:0][DIFF_W:0]   div_diff;
    logic [AXES-1:0][DIFF_W+Q_W-1:0]      prod1;
    logic [AXES-1:0][DIFF_W+GAIN_W-1:0]   prod2;
    logic signed [AXES-1:0][DIFF_W+1:0]   term;
    logic signed [AXES-1:0][DIFF_W+1:0]   acc;
    logic                     out_free;

    assign q_ready        = (state_reg == S_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;
    assign out_free       = !out_valid_reg || result.ready;

    always_comb
    begin
        rem_sh  = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        root_ge = (rem_sh >= trial);
        e       = $signed({1'b0, root_reg}) - $signed({3'b000, rest_length});
        for (int i = 0; i < AXES; i++)
        begin
            div_ge[i]   = (drem_reg[i] >= {1'b0, root_reg});
            div_diff[i] = div_ge[i] ? drem_reg[i] - {1'b0, root_reg} : drem_reg[i];
            prod1[i]    = ae_reg * quo_reg[i];
            prod2[i]    = m_reg[i] * spring_gain;
            if (zero_reg)
                term[i] = '0;
            else if (eneg_reg == item_reg.dneg[i])
                term[i] = -$signed({2'b00, c_reg[i]});
            else
                term[i] = $signed({2'b00, c_reg[i]});
            acc[i] = $signed({{(DIFF_W+2-DATA_W){sum_reg[i][DATA_W-1]}}, sum_reg[i]})
                   + term[i];
            if (acc[i][DIFF_W+1:DATA_W-1] == '0 || acc[i][DIFF_W+1:DATA_W-1] == '1)
                sum_next[i] = acc[i][DATA_W-1:0];
            else if (acc[i][DIFF_W+1])
                sum_next[i] = {1'b1, {(DATA_W-1){1'b0}}};
            else
                sum_next[i] = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_ACC && item_reg.last && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                        state_reg <= S_SQ;
                end
                S_SQ:
                    state_reg <= S_SUM;
                S_SUM:
                begin
                    cnt_reg   <= CNT_W'(ROOT_STEPS - 1);
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    cnt_reg   <= CNT_W'(FRAC_BITS);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= S_MUL1;
                end
                S_MUL1:
                    state_reg <= S_MUL2;
                S_MUL2:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    if (!item_reg.last)
                    begin
                        sum_reg   <= sum_next;
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        sum_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                item_reg <= q_data;
            S_SQ:
            begin
                for (int i = 0; i < AXES; i++)
                    sq_reg[i] <= {{(SQ_W-DIFF_W){1'b0}}, item_reg.ad[i]}
                               * {{(SQ_W-DIFF_W){1'b0}}, item_reg.ad[i]};
            end
            S_SUM:
            begin
                rad_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                rem_reg  <= '0;
                root_reg <= '0;
            end
            S_ROOT:
            begin
                rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
                if (root_ge)
                begin
                    rem_reg  <= REM_W'(rem_sh - trial);
                    root_reg <= {root_reg[DIFF_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= REM_W'(rem_sh);
                    root_reg <= {root_reg[DIFF_W-2:0], 1'b0};
                end
            end
            S_PREP:
            begin
                eneg_reg <= e[DIFF_W];
                ae_reg   <= e[DIFF_W] ? DIFF_W'(-e) : e[DIFF_W-1:0];
                zero_reg <= (root_reg == '0);
                for (int i = 0; i < AXES; i++)
                begin
                    drem_reg[i] <= {1'b0, item_reg.ad[i]};
                    quo_reg[i]  <= '0;
                end
            end
            S_DIV:
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    drem_reg[i] <= {div_diff[i][DIFF_W-1:0], 1'b0};
                    quo_reg[i]  <= {quo_reg[i][Q_W-2:0], div_ge[i]};
                end
            end
            S_MUL1:
            begin
                for (int i = 0; i < AXES; i++)
                    m_reg[i] <= prod1[i][FRAC_BITS +: DIFF_W];
            end
            S_MUL2:
            begin
                for (int i = 0; i < AXES; i++)
                    c_reg[i] <= prod2[i][GAIN_W +: DIFF_W];
            end
            S_ACC:
            begin
                if (item_reg.last && out_free)
                begin
                    out_data_reg.accel_x <= sum_next[0];
                    out_data_reg.accel_y <= sum_next[1];
                    out_data_reg.accel_z <= sum_next[2];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> hw/rtl/attractor_spring_force.sv
// The back end holds one item and takes no new one until it is through with it;
// its pace is set by the 33-step square root and the FRAC_BITS + 1 step dividers.
// The front end and queue take up to three further items meanwhile.
// Reset: rst_n asynchronous, clears sums and handshake state; registers
// return to spring_gain 0.1 and rest_length 0.25.
module attractor_spring_force #(
    parameter int FRAC_BITS = asf_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    asf_item_if.sink                  item,
    asf_result_if.source              result,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [asf_pkg::CFG_W-1:0] cfg_data
);
    import asf_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    logic [REST_W-1:0] rest_reg;
    diff_item_t        f_data;
    logic              f_valid;
    logic              f_ready;
    diff_item_t        b_data;
    logic              b_valid;
    logic              b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            rest_reg <= REST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SPRING_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_REST_LENGTH: rest_reg <= cfg_data[REST_W-1:0];
                default:         gain_reg <= gain_reg;
            endcase
        end
    end

    asf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_data  (f_data),
        .q_valid (f_valid),
        .q_ready (f_ready)
    );

    asf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    asf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (b_valid),
        .q_ready     (b_ready),
        .q_data      (b_data),
        .spring_gain (gain_reg),
        .rest_length (rest_reg),
        .result      (result)
    );

endmodule

>>> hw/rtl/asf_checker.sv
// Port-level checks for attractor_spring_force, attached by bind.
// Depends on asf_pkg and the top level.
module asf_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               in_last,
    input  logic               out_valid,
    input  logic               out_ready,
    input  asf_pkg::out_item_t out_data
);
    import asf_pkg::*;

    // last-attractor transactions taken but not yet delivered
    logic [2:0] pend_reg;
    logic       last_in;
    logic       out_xfer;

    assign last_in  = in_valid && in_ready && in_last;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 3'd0;
        else if (last_in && !out_xfer)
            pend_reg <= pend_reg + 3'd1;
        else if (out_xfer && !last_in)
            pend_reg <= pend_reg - 3'd1;
    end

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("result without a pending last attractor");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd5)
        else $error("more pending results than the pipeline holds");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind attractor_spring_force asf_checker u_asf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_last   (item.payload.last_attractor),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.payload)
);
